### rtl/core/ffal_pkg.sv
// Shared types and constants of the first-fit free-list allocator.
// Holds the controller state encoding, the command and status bundles
// between controller and datapath, and the result and register codes.
`timescale 1ns / 1ps
`default_nettype none

package ffal_pkg;

    // Fixed field widths of the request and result beats.
    localparam int SLICE_SIZE_W  = 24;
    localparam int ALIGN_LOG2_W  = 5;
    localparam int SLICE_COUNT_W = 7;
    localparam int FIELD_ADDR_W  = 32;
    localparam int SLICE_INDEX_W = 6;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_HEAP_BASE = 1'b0,
        REG_HEAP_SIZE = 1'b1
    } cfg_reg_t;

    // Kind of result loaded into the output register.
    typedef enum logic [2:0] {
        OUT_SLICE,
        OUT_TOO_LARGE,
        OUT_NO_SPACE,
        OUT_FREE_OK,
        OUT_FREE_FULL
    } out_kind_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_REBUILD,
        S_DECODE,
        S_A_CHK,
        S_A_RD,
        S_A_AB,
        S_A_CMP,
        S_A_EMIT,
        S_F1_RD,
        S_F1_EL,
        S_F1_END,
        S_F2_RD,
        S_F2_EL,
        S_F2_END,
        S_F_OK,
        S_F_FULL,
        S_ERR_TL,
        S_ERR_NS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      rebuild;
        logic      ld_req;
        logic      rd_issue;
        logic      ab_ld;
        logic      a_cmp;
        logic      walk_tail;
        logic      walk_el;
        logic      walk_wr;
        logic      walk_clr;
        logic      commit;
        logic      out_load;
        out_kind_t out_kind;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pend;
        logic mode_free;
        logic empty_free;
        logic bad_alloc;
        logic i_done;
        logic fit;
        logic took_new;
        logic ins_done;
        logic too_many;
        logic out_free;
        logic last_slice;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/ffal_req_if.sv
// Request channel of the allocator: valid/ready handshake and request fields.
// Depends on ffal_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffal_req_if
    import ffal_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SLICE_SIZE_W-1:0]  slice_size;
    logic [ALIGN_LOG2_W-1:0]  align_log2;
    logic [SLICE_COUNT_W-1:0] slice_count;
    logic [FIELD_ADDR_W-1:0]  free_begin;
    logic [FIELD_ADDR_W-1:0]  free_end;

    modport source (
        output valid, mode, slice_size, align_log2, slice_count, free_begin, free_end,
        input  ready
    );

    modport sink (
        input  valid, mode, slice_size, align_log2, slice_count, free_begin, free_end,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/ffal_rsp_if.sv
// Result channel of the allocator: valid/ready handshake and result fields.
// Depends on ffal_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ffal_rsp_if
    import ffal_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [FIELD_ADDR_W-1:0]  block_begin;
    logic [FIELD_ADDR_W-1:0]  block_end;
    logic [SLICE_INDEX_W-1:0] slice_index;
    logic [FIELD_ADDR_W-1:0]  slice_start;
    logic                     last;

    modport source (
        output valid, status, block_begin, block_end, slice_index, slice_start, last,
        input  ready
    );

    modport sink (
        input  valid, status, block_begin, block_end, slice_index, slice_start, last,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/ffal_cfg.sv
// APB-style configuration registers of the allocator: heap_base and heap_size.
// Depends on ffal_pkg; flags each heap_size write so the free list is rebuilt.
`timescale 1ns / 1ps
`default_nettype none

module ffal_cfg
    import ffal_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CFG_DATA_W-1:0] heap_base,
    output logic      [CFG_DATA_W-1:0] heap_size,
    output logic                       size_wr
);

    logic [CFG_DATA_W-1:0] heap_base_reg, heap_base_next;
    logic [CFG_DATA_W-1:0] heap_size_reg, heap_size_next;
    logic                  wr_en;
    cfg_reg_t              reg_sel;

    // Registers are word aligned; the word index picks the register.
    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write decode.
    always_comb
    begin
        heap_base_next = heap_base_reg;
        heap_size_next = heap_size_reg;
        size_wr        = 1'b0;
        if (wr_en)
        begin
            case (reg_sel)
                REG_HEAP_BASE: heap_base_next = pwdata;
                REG_HEAP_SIZE:
                begin
                    heap_size_next = pwdata;
                    size_wr        = 1'b1;
                end
                default: heap_base_next = heap_base_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_sel)
            REG_HEAP_BASE: prdata = heap_base_reg;
            REG_HEAP_SIZE: prdata = heap_size_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            heap_size_reg <= '0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
            heap_size_reg <= heap_size_next;
        end
    end

    assign heap_base = heap_base_reg;
    assign heap_size = heap_size_reg;

endmodule

`default_nettype wire

### rtl/core/ffal_ctrl.sv
// Controller state machine of the allocator: sequences the table scan, the
// two-pass free merge and result emission. Depends on ffal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffal_ctrl
    import ffal_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg, state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.pend)
                    state_next = S_REBUILD;
                else if (req_valid)
                    state_next = S_DECODE;
            end
            S_REBUILD: state_next = S_IDLE;
            S_DECODE:
            begin
                if (!sts.mode_free)
                    state_next = S_A_CHK;
                else if (sts.empty_free)
                    state_next = S_F_OK;
                else
                    state_next = S_F1_RD;
            end
            S_A_CHK:   state_next = sts.bad_alloc ? S_ERR_TL : S_A_RD;
            S_A_RD:    state_next = sts.i_done ? S_ERR_NS : S_A_AB;
            S_A_AB:    state_next = S_A_CMP;
            S_A_CMP:   state_next = sts.fit ? S_A_EMIT : S_A_RD;
            S_A_EMIT:
            begin
                if (sts.out_free && sts.last_slice)
                    state_next = S_IDLE;
            end
            S_F1_RD:   state_next = sts.i_done ? S_F1_END : S_F1_EL;
            S_F1_EL:   state_next = sts.took_new ? S_F1_EL : S_F1_RD;
            S_F1_END:  state_next = sts.too_many ? S_F_FULL : S_F2_RD;
            S_F2_RD:   state_next = sts.i_done ? S_F2_END : S_F2_EL;
            S_F2_EL:   state_next = sts.took_new ? S_F2_EL : S_F2_RD;
            S_F2_END:  state_next = S_F_OK;
            S_F_OK, S_F_FULL, S_ERR_TL, S_ERR_NS:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = OUT_SLICE;
        req_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready  = !sts.pend;
                cmd.accept = !sts.pend && req_valid;
            end
            S_REBUILD: cmd.rebuild = 1'b1;
            S_DECODE:  cmd.ld_req  = 1'b1;
            S_A_CHK:   cmd.ld_req  = 1'b0;
            S_A_RD:    cmd.rd_issue = !sts.i_done;
            S_A_AB:    cmd.ab_ld   = 1'b1;
            S_A_CMP:   cmd.a_cmp   = 1'b1;
            S_A_EMIT:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = OUT_SLICE;
            end
            S_F1_RD, S_F2_RD:
            begin
                cmd.rd_issue  = !sts.i_done;
                cmd.walk_tail = sts.i_done && !sts.ins_done;
                cmd.walk_wr   = (state_reg == S_F2_RD);
            end
            S_F1_EL, S_F2_EL:
            begin
                cmd.walk_el = 1'b1;
                cmd.walk_wr = (state_reg == S_F2_EL);
            end
            S_F1_END:  cmd.walk_clr = 1'b1;
            S_F2_END:  cmd.commit   = 1'b1;
            S_F_OK:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = OUT_FREE_OK;
            end
            S_F_FULL:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = OUT_FREE_FULL;
            end
            S_ERR_TL:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = OUT_TOO_LARGE;
            end
            S_ERR_NS:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = OUT_NO_SPACE;
            end
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/core/ffal_dp.sv
// Datapath of the allocator: free-region table memory (two banks), request
// registers, fit arithmetic, merge walker and the result register.
// Depends on ffal_pkg; driven by ffal_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ffal_dp
    import ffal_pkg::*;
#(
    parameter int MAX_FREE_REGIONS = 16,
    parameter int ADDR_WIDTH       = 32,
    parameter int MAX_SLICES       = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    output dp_sts_t                       sts,
    input  wire logic                     mode,
    input  wire logic [SLICE_SIZE_W-1:0]  slice_size,
    input  wire logic [ALIGN_LOG2_W-1:0]  align_log2,
    input  wire logic [SLICE_COUNT_W-1:0] slice_count,
    input  wire logic [FIELD_ADDR_W-1:0]  free_begin,
    input  wire logic [FIELD_ADDR_W-1:0]  free_end,
    input  wire logic [CFG_DATA_W-1:0]    heap_base,
    input  wire logic [CFG_DATA_W-1:0]    heap_size,
    input  wire logic                     size_wr,
    input  wire logic                     rsp_ready,
    output logic                          rsp_valid,
    output logic [1:0]                    status,
    output logic [FIELD_ADDR_W-1:0]       block_begin,
    output logic [FIELD_ADDR_W-1:0]       block_end,
    output logic [SLICE_INDEX_W-1:0]      slice_index,
    output logic [FIELD_ADDR_W-1:0]       slice_start,
    output logic                          last
);

    localparam int AW  = ADDR_WIDTH;
    localparam int IW  = (MAX_FREE_REGIONS > 1) ? $clog2(MAX_FREE_REGIONS) : 1;
    localparam int CW  = $clog2(MAX_FREE_REGIONS + 1);
    localparam int OCW = $clog2(MAX_FREE_REGIONS + 2);
    localparam int MD  = 2 ** (IW + 1);
    localparam int RQW = 39;
    localparam int WW  = ((AW > RQW) ? AW : RQW) + 2;
    localparam int SW  = ((AW > CFG_DATA_W) ? AW : CFG_DATA_W) + 1;
    localparam int AMW = 31;
    localparam int ASW = 32;

    // Region table: two banks, one written while the other is read on a merge.
    logic [AW-1:0] mem_begin [MD];
    logic [AW-1:0] mem_end   [MD];

    // Request registers.
    logic                     mode_reg, mode_next;
    logic [SLICE_SIZE_W-1:0]  ssz_reg, ssz_next;
    logic [AMW-1:0]           am_reg, am_next;
    logic [ASW-1:0]           aslice_reg, aslice_next;
    logic [SLICE_COUNT_W-1:0] slices_reg, slices_next;
    logic [RQW-1:0]           req_reg, req_next;
    logic [AW-1:0]            fb_reg, fb_next;
    logic [AW-1:0]            fe_reg, fe_next;
    logic [AW-1:0]            rd_b_reg, rd_e_reg;
    logic [WW-1:0]            ab_reg, ab_next;
    logic [WW-1:0]            sal_reg, sal_next;
    logic [AW-1:0]            blk_b_reg, blk_b_next;
    logic [AW-1:0]            blk_e_reg, blk_e_next;
    logic [SLICE_COUNT_W-1:0] k_reg, k_next;
    logic [AW-1:0]            prev_e_reg, prev_e_next;

    // Control registers.
    logic                     out_valid_reg, out_valid_next;
    logic                     pend_reg, pend_next;
    logic                     bank_reg, bank_next;
    logic [CW-1:0]            rcnt_reg, rcnt_next;
    logic [CW-1:0]            i_reg, i_next;
    logic                     ins_reg, ins_next;
    logic                     prev_v_reg, prev_v_next;
    logic [OCW-1:0]           ocnt_reg, ocnt_next;

    // Result register.
    status_t                  o_st_reg, o_st_next;
    logic [FIELD_ADDR_W-1:0]  o_bb_reg, o_bb_next;
    logic [FIELD_ADDR_W-1:0]  o_be_reg, o_be_next;
    logic [SLICE_INDEX_W-1:0] o_idx_reg, o_idx_next;
    logic [FIELD_ADDR_W-1:0]  o_ss_reg, o_ss_next;
    logic                     o_last_reg, o_last_next;

    // Combinational helpers.
    logic [AMW-1:0]           am_in;
    logic [ASW-1:0]           aslice_in;
    logic [RQW-1:0]           prod;
    logic [WW-1:0]            ab_calc;
    logic [WW-1:0]            fit_sum;
    logic [AW-1:0]            bend;
    logic                     fit;
    logic                     took_new;
    logic                     el_go;
    logic                     el_new;
    logic [AW-1:0]            el_b;
    logic [AW-1:0]            el_e;
    logic                     merge;
    logic [OCW-1:0]           ocnt_m1;
    logic [AW-1:0]            base_m;
    logic [SW-1:0]            end_sum;
    logic [AW-1:0]            end_sat;
    logic                     out_free;
    logic                     last_slice;
    logic                     too_many;
    logic [IW:0]              rd_addr;
    logic                     wb_en, we_en;
    logic [IW:0]              wa_b, wa_e;
    logic [AW-1:0]            wd_b, wd_e;

    // Slice alignment mask and the slice size rounded up to it.
    assign am_in     = AMW'((ASW'(1) << align_log2) - ASW'(1));
    assign aslice_in = (ASW'(slice_size) + ASW'(am_in)) & ~ASW'(am_in);
    assign prod      = aslice_reg * slices_reg;

    // Fit test against the region held in the read registers.
    assign ab_calc = (WW'(rd_b_reg) + WW'(am_reg)) & ~WW'(am_reg);
    assign fit_sum = ab_reg + WW'(req_reg);
    assign fit     = fit_sum < WW'(rd_e_reg);
    assign bend    = AW'(fit_sum);

    // Merge walker: one list element per step, the freed range or a table entry.
    assign took_new = !ins_reg && (rd_b_reg >= fe_reg);
    assign el_go    = cmd.walk_tail || cmd.walk_el;
    assign el_new   = cmd.walk_tail || (cmd.walk_el && took_new);
    assign el_b     = el_new ? fb_reg : rd_b_reg;
    assign el_e     = el_new ? fe_reg : rd_e_reg;
    assign merge    = prev_v_reg && (el_b == prev_e_reg);
    assign ocnt_m1  = ocnt_reg - OCW'(1);
    assign too_many = ocnt_reg > OCW'(MAX_FREE_REGIONS);

    // Heap bounds for a rebuild, end saturated at the top address.
    assign base_m  = AW'(heap_base);
    assign end_sum = SW'(base_m) + SW'(heap_size);
    assign end_sat = (end_sum > SW'({AW{1'b1}})) ? {AW{1'b1}} : AW'(end_sum);

    assign out_free   = !out_valid_reg || rsp_ready;
    assign last_slice = (k_reg + SLICE_COUNT_W'(1)) == slices_reg;
    assign rd_addr    = {bank_reg, i_reg[IW-1:0]};

    // Status to the controller.
    always_comb
    begin
        sts            = '0;
        sts.pend       = pend_reg;
        sts.mode_free  = mode_reg;
        sts.empty_free = fe_reg <= fb_reg;
        sts.bad_alloc  = (slices_reg == '0)
                      || (slices_reg > SLICE_COUNT_W'(MAX_SLICES))
                      || (req_reg >= RQW'(heap_size));
        sts.i_done     = i_reg == rcnt_reg;
        sts.fit        = fit;
        sts.took_new   = took_new;
        sts.ins_done   = ins_reg;
        sts.too_many   = too_many;
        sts.out_free   = out_free;
        sts.last_slice = last_slice;
    end

    // Table write port selection.
    always_comb
    begin
        wb_en = 1'b0;
        we_en = 1'b0;
        wa_b  = '0;
        wa_e  = '0;
        wd_b  = '0;
        wd_e  = '0;
        if (cmd.rebuild)
        begin
            wb_en = 1'b1;
            we_en = 1'b1;
            wa_b  = {bank_reg, {IW{1'b0}}};
            wa_e  = {bank_reg, {IW{1'b0}}};
            wd_b  = base_m;
            wd_e  = end_sat;
        end
        else if (cmd.a_cmp && fit)
        begin
            wb_en = 1'b1;
            wa_b  = rd_addr;
            wd_b  = bend;
        end
        else if (el_go && cmd.walk_wr)
        begin
            if (merge)
            begin
                we_en = 1'b1;
                wa_e  = {!bank_reg, ocnt_m1[IW-1:0]};
                wd_e  = el_e;
            end
            else
            begin
                wb_en = 1'b1;
                we_en = 1'b1;
                wa_b  = {!bank_reg, ocnt_reg[IW-1:0]};
                wa_e  = {!bank_reg, ocnt_reg[IW-1:0]};
                wd_b  = el_b;
                wd_e  = el_e;
            end
        end
    end

    // Register next values.
    always_comb
    begin
        mode_next      = mode_reg;
        ssz_next       = ssz_reg;
        am_next        = am_reg;
        aslice_next    = aslice_reg;
        slices_next    = slices_reg;
        req_next       = req_reg;
        fb_next        = fb_reg;
        fe_next        = fe_reg;
        ab_next        = ab_reg;
        sal_next       = sal_reg;
        blk_b_next     = blk_b_reg;
        blk_e_next     = blk_e_reg;
        k_next         = k_reg;
        prev_e_next    = prev_e_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        bank_next      = bank_reg;
        rcnt_next      = rcnt_reg;
        i_next         = i_reg;
        ins_next       = ins_reg;
        prev_v_next    = prev_v_reg;
        ocnt_next      = ocnt_reg;
        o_st_next      = o_st_reg;
        o_bb_next      = o_bb_reg;
        o_be_next      = o_be_reg;
        o_idx_next     = o_idx_reg;
        o_ss_next      = o_ss_reg;
        o_last_next    = o_last_reg;

        // Request capture.
        if (cmd.accept)
        begin
            mode_next   = mode;
            ssz_next    = slice_size;
            am_next     = am_in;
            aslice_next = aslice_in;
            slices_next = slice_count;
            fb_next     = AW'(free_begin);
            fe_next     = AW'(free_end);
        end
        if (cmd.ld_req)
            req_next = prod;
        if (cmd.ab_ld)
            ab_next = ab_calc;

        // Scan index and walker state.
        if (cmd.accept || cmd.walk_clr)
        begin
            i_next      = '0;
            ins_next    = 1'b0;
            prev_v_next = 1'b0;
            ocnt_next   = '0;
        end
        if (cmd.a_cmp)
        begin
            if (fit)
            begin
                sal_next   = ab_reg;
                blk_b_next = rd_b_reg;
                blk_e_next = bend;
                k_next     = '0;
            end
            else
                i_next = i_reg + CW'(1);
        end
        if (el_go)
        begin
            prev_v_next = 1'b1;
            prev_e_next = el_e;
            if (!merge)
                ocnt_next = ocnt_reg + OCW'(1);
            if (el_new)
                ins_next = 1'b1;
            else
                i_next = i_reg + CW'(1);
        end

        // Free list rebuild and merge commit.
        if (cmd.rebuild)
        begin
            rcnt_next = CW'(1);
            pend_next = 1'b0;
        end
        if (cmd.commit)
        begin
            bank_next = !bank_reg;
            rcnt_next = CW'(ocnt_reg);
        end
        if (size_wr)
            pend_next = 1'b1;

        // Result register.
        if (rsp_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            o_idx_next     = '0;
            o_ss_next      = '0;
            o_last_next    = 1'b1;
            o_bb_next      = '0;
            o_be_next      = '0;
            case (cmd.out_kind)
                OUT_SLICE:
                begin
                    o_st_next   = ST_OK;
                    o_bb_next   = FIELD_ADDR_W'(blk_b_reg);
                    o_be_next   = FIELD_ADDR_W'(blk_e_reg);
                    o_idx_next  = k_reg[SLICE_INDEX_W-1:0];
                    o_ss_next   = FIELD_ADDR_W'(sal_reg);
                    o_last_next = last_slice;
                    k_next      = k_reg + SLICE_COUNT_W'(1);
                    sal_next    = (sal_reg + WW'(ssz_reg) + WW'(am_reg)) & ~WW'(am_reg);
                end
                OUT_TOO_LARGE: o_st_next = ST_TOO_LARGE;
                OUT_NO_SPACE:  o_st_next = ST_NO_SPACE;
                OUT_FREE_OK:
                begin
                    o_st_next = ST_OK;
                    o_bb_next = FIELD_ADDR_W'(fb_reg);
                    o_be_next = FIELD_ADDR_W'(fe_reg);
                end
                OUT_FREE_FULL:
                begin
                    o_st_next = ST_FULL;
                    o_bb_next = FIELD_ADDR_W'(fb_reg);
                    o_be_next = FIELD_ADDR_W'(fe_reg);
                end
                default:       o_st_next = ST_OK;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b1;
            bank_reg      <= 1'b0;
            rcnt_reg      <= CW'(1);
            i_reg         <= '0;
            ins_reg       <= 1'b0;
            prev_v_reg    <= 1'b0;
            ocnt_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            bank_reg      <= bank_next;
            rcnt_reg      <= rcnt_next;
            i_reg         <= i_next;
            ins_reg       <= ins_next;
            prev_v_reg    <= prev_v_next;
            ocnt_reg      <= ocnt_next;
            k_reg         <= k_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        ssz_reg    <= ssz_next;
        am_reg     <= am_next;
        aslice_reg <= aslice_next;
        slices_reg <= slices_next;
        req_reg    <= req_next;
        fb_reg     <= fb_next;
        fe_reg     <= fe_next;
        ab_reg     <= ab_next;
        sal_reg    <= sal_next;
        blk_b_reg  <= blk_b_next;
        blk_e_reg  <= blk_e_next;
        prev_e_reg <= prev_e_next;
        o_st_reg   <= o_st_next;
        o_bb_reg   <= o_bb_next;
        o_be_reg   <= o_be_next;
        o_idx_reg  <= o_idx_next;
        o_ss_reg   <= o_ss_next;
        o_last_reg <= o_last_next;
    end

    // Region table memory: one write port per array, registered read.
    always_ff @(posedge clk)
    begin
        if (wb_en)
            mem_begin[wa_b] <= wd_b;
        if (we_en)
            mem_end[wa_e] <= wd_e;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_b_reg <= mem_begin[rd_addr];
            rd_e_reg <= mem_end[rd_addr];
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = o_st_reg;
    assign block_begin = o_bb_reg;
    assign block_end   = o_be_reg;
    assign slice_index = o_idx_reg;
    assign slice_start = o_ss_reg;
    assign last        = o_last_reg;

    // The table always holds between one and MAX_FREE_REGIONS regions.
    a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rcnt_reg != '0) && (rcnt_reg <= CW'(MAX_FREE_REGIONS)))
        else $error("region count out of range");

    // A result is only loaded when the output register is free or being drained.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // A merged table is only committed when it fits.
    a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !too_many)
        else $error("oversized table committed");

    // After a commit the count follows the merged list length.
    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (rcnt_reg == CW'($past(ocnt_reg))))
        else $error("region count not updated on commit");

endmodule

`default_nettype wire

### rtl/core/first_fit_aligned_free_list_allocator.sv
// First-fit aligned free-list allocator, top level.
// Request beats arrive on req (ffal_req_if, valid/ready); result beats leave on
// rsp (ffal_rsp_if, valid/ready). heap_base and heap_size sit on an APB-style
// port at byte addresses 0 and 4; writes complete in the access cycle.
// An allocate beat gives one result beat per slice, the last one flagged by
// last; errors and frees give a single beat. Items are processed one at a time.
// Allocate: the table regions are scanned in order, each region costing a
// read, an align and a compare, and the first region that fits gives the
// slices. A too_large error is answered before the scan, no_space once all n
// table regions have failed.
// Free: the merge walks the n table regions twice, the second pass writing
// the merged list to the other bank; an empty range answers without a walk.
// After reset, and after every heap_size write, a one-cycle rebuild writes the
// single heap region before the next request is accepted.
// When the receiver stalls, the result register holds the beat and the
// controller waits; once the last beat of an item is loaded the next request
// can be accepted while that beat is still waiting.
// Depends on ffal_pkg, ffal_req_if, ffal_rsp_if, ffal_cfg, ffal_ctrl, ffal_dp.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_aligned_free_list_allocator
    import ffal_pkg::*;
#(
    parameter int MAX_FREE_REGIONS = 16,
    parameter int ADDR_WIDTH       = 32,
    parameter int MAX_SLICES       = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ffal_req_if.sink                   req,
    ffal_rsp_if.source                 rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CFG_DATA_W-1:0] heap_base;
    logic [CFG_DATA_W-1:0] heap_size;
    logic                  size_wr;
    logic                  req_ready;
    dp_cmd_t               cmd;
    dp_sts_t               sts;

    // Configuration registers.
    ffal_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .heap_base (heap_base),
        .heap_size (heap_size),
        .size_wr   (size_wr)
    );

    // Sequencer.
    ffal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    assign req.ready = req_ready;

    // Table, arithmetic and result register.
    ffal_dp #(
        .MAX_FREE_REGIONS (MAX_FREE_REGIONS),
        .ADDR_WIDTH       (ADDR_WIDTH),
        .MAX_SLICES       (MAX_SLICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (req.mode),
        .slice_size  (req.slice_size),
        .align_log2  (req.align_log2),
        .slice_count (req.slice_count),
        .free_begin  (req.free_begin),
        .free_end    (req.free_end),
        .heap_base   (heap_base),
        .heap_size   (heap_size),
        .size_wr     (size_wr),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .status      (rsp.status),
        .block_begin (rsp.block_begin),
        .block_end   (rsp.block_end),
        .slice_index (rsp.slice_index),
        .slice_start (rsp.slice_start),
        .last        (rsp.last)
    );

endmodule

`default_nettype wire
